[design/imm_pkg.sv]
package imm_pkg;

    // Default and widths of the fixed fields
    localparam int MAX_DIM_DEF = 8;
    localparam int CFG_W       = 4;
    localparam int CFG_ADDR_W  = 2;
    localparam int REQ_W       = 2;
    localparam int POS_W       = 3;
    localparam int VALUE_W     = 32;
    localparam int DATA_W      = 40;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COLS_B    = 2'd2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
    localparam logic [REQ_W-1:0] REQ_START  = 2'd2;

    // Controller to datapath: one multiply-accumulate step
    typedef struct packed {
        logic issue;
        logic first_k;
        logic last_k;
        logic last_entry;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_full;
    } stat_t;

endpackage

[design/imm_ctrl.sv]
module imm_ctrl #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF,
    parameter int IDX_W   = $clog2(MAX_DIM),
    parameter int CNT_W   = IDX_W + 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [imm_pkg::REQ_W-1:0] in_req,
    input  logic [CNT_W-1:0]         nr,
    input  logic [CNT_W-1:0]         nk,
    input  logic [CNT_W-1:0]         nc,
    output imm_pkg::cmd_t            cmd,
    output logic [IDX_W-1:0]         idx_i,
    output logic [IDX_W-1:0]         idx_j,
    output logic [IDX_W-1:0]         idx_k,
    input  imm_pkg::stat_t           stat
);
    import imm_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_WAIT, ST_RUN} state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             i_last, j_last, k_last;

    assign i_last = (CNT_W'(i_reg) + CNT_W'(1)) == nr;
    assign j_last = (CNT_W'(j_reg) + CNT_W'(1)) == nc;
    assign k_last = (CNT_W'(k_reg) + CNT_W'(1)) == nk;

    assign in_ready = (state_reg == ST_IDLE);
    assign idx_i    = i_reg;
    assign idx_j    = j_reg;
    assign idx_k    = k_reg;

    // Walk entries in row-major order, inner index fastest
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        cmd.issue      = 1'b0;
        cmd.first_k    = (k_reg == '0);
        cmd.last_k     = k_last;
        cmd.last_entry = i_last && j_last;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_req == REQ_START)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                // hold until the pipeline is empty and the previous entry has left the output register
                if (!stat.pipe_busy && !stat.out_full)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (k_last)
                begin
                    k_next = '0;
                    if (j_last)
                    begin
                        j_next = '0;
                        if (i_last)
                        begin
                            i_next     = '0;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            i_next     = i_reg + IDX_W'(1);
                            state_next = ST_WAIT;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + IDX_W'(1);
                        state_next = ST_WAIT;
                    end
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // An entry starts only on an empty pipeline and output register
    a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && cmd.first_k) |-> (!stat.pipe_busy && !stat.out_full))
        else $error("entry started while pipeline or output busy");

    // No input transaction is taken while steps are issued
    a_no_accept_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !in_ready)
        else $error("input ready during issue");

endmodule

[design/imm_datapath.sv]
module imm_datapath #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF,
    parameter int IDX_W   = $clog2(MAX_DIM),
    parameter int CNT_W   = IDX_W + 1,
    parameter int ADDR_W  = $clog2(MAX_DIM * MAX_DIM)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [CNT_W-1:0]            nr,
    input  logic [CNT_W-1:0]            nk,
    input  logic [CNT_W-1:0]            nc,
    input  logic                        ld_en,
    input  logic [imm_pkg::REQ_W-1:0]   ld_req,
    input  logic [imm_pkg::POS_W-1:0]   ld_row,
    input  logic [imm_pkg::POS_W-1:0]   ld_col,
    input  logic [imm_pkg::VALUE_W-1:0] ld_value,
    input  imm_pkg::cmd_t               cmd,
    input  logic [IDX_W-1:0]            idx_i,
    input  logic [IDX_W-1:0]            idx_j,
    input  logic [IDX_W-1:0]            idx_k,
    output imm_pkg::stat_t              stat,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [imm_pkg::POS_W-1:0]   out_row,
    output logic [imm_pkg::POS_W-1:0]   out_col,
    output logic [imm_pkg::VALUE_W-1:0] out_value,
    output logic                        out_last
);
    import imm_pkg::*;

    logic [VALUE_W-1:0] mem_a [MAX_DIM*MAX_DIM];
    logic [VALUE_W-1:0] mem_b [MAX_DIM*MAX_DIM];

    logic               wr_a, wr_b;
    logic [ADDR_W-1:0]  wr_addr, rd_addr_a, rd_addr_b;

    logic [VALUE_W-1:0] rd_a_reg, rd_b_reg, prod_reg, acc_reg, acc_next;
    logic               v1_reg, v2_reg, out_valid_reg;
    logic               f1_reg, f2_reg, lk1_reg, lk2_reg, le1_reg, le2_reg;
    logic [IDX_W-1:0]   r1_reg, r2_reg, c1_reg, c2_reg;
    logic               done;
    logic [VALUE_W-1:0] out_value_reg;
    logic [IDX_W-1:0]   out_row_reg, out_col_reg;
    logic               out_last_reg;

    // Range-check loads against the current sizes
    assign wr_a = ld_en && (ld_req == REQ_LOAD_A)
                  && (32'(ld_row) < 32'(nr)) && (32'(ld_col) < 32'(nk));
    assign wr_b = ld_en && (ld_req == REQ_LOAD_B)
                  && (32'(ld_row) < 32'(nk)) && (32'(ld_col) < 32'(nc));

    assign wr_addr   = ADDR_W'(ADDR_W'(ld_row) * ADDR_W'(MAX_DIM) + ADDR_W'(ld_col));
    assign rd_addr_a = ADDR_W'(ADDR_W'(idx_i) * ADDR_W'(MAX_DIM) + ADDR_W'(idx_k));
    assign rd_addr_b = ADDR_W'(ADDR_W'(idx_k) * ADDR_W'(MAX_DIM) + ADDR_W'(idx_j));

    // Element stores: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[wr_addr] <= ld_value;
        end
        if (wr_b)
        begin
            mem_b[wr_addr] <= ld_value;
        end
        if (cmd.issue)
        begin
            rd_a_reg <= mem_a[rd_addr_a];
            rd_b_reg <= mem_b[rd_addr_b];
        end
    end

    // Multiply and accumulate stages, low 32 bits kept
    assign acc_next = f2_reg ? prod_reg : (acc_reg + prod_reg);
    assign done     = v2_reg && lk2_reg;

    always_ff @(posedge clk)
    begin
        r1_reg  <= idx_i;
        c1_reg  <= idx_j;
        f1_reg  <= cmd.first_k;
        lk1_reg <= cmd.last_k;
        le1_reg <= cmd.last_entry;
        prod_reg <= VALUE_W'(rd_a_reg * rd_b_reg);
        r2_reg  <= r1_reg;
        c2_reg  <= c1_reg;
        f2_reg  <= f1_reg;
        lk2_reg <= lk1_reg;
        le2_reg <= le1_reg;
        if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
        if (done)
        begin
            out_value_reg <= acc_next;
            out_row_reg   <= r2_reg;
            out_col_reg   <= c2_reg;
            out_last_reg  <= le2_reg;
        end
    end

    // Stage valid bits and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.pipe_busy = v1_reg || v2_reg;
    assign stat.out_full  = out_valid_reg;
    assign out_valid      = out_valid_reg;
    assign out_row        = POS_W'(out_row_reg);
    assign out_col        = POS_W'(out_col_reg);
    assign out_value      = out_value_reg;
    assign out_last       = out_last_reg;

    // A finished entry never lands on a waiting result
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !out_valid_reg)
        else $error("entry finished while output register full");

    // Loads never coincide with an issued step; the drain may still run
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_a || wr_b) |-> !cmd.issue)
        else $error("store written while a step is issued");

endmodule

[design/integer_matrix_multiply_core.sv]
// Integer matrix multiply core.
// Input stream (s_*): each transaction is a request; tuser carries the kind
// (load A element, load B element, start) and tdata the row, column and
// value of a load. A load is dropped when its row or
// column lies outside the configured size. A start walks the product.
// Output stream (m_*): one transaction per product entry in row-major order,
// tlast on the final entry. Values are 32-bit sums wrapped like C int.
// Each entry takes inner_dim multiply-accumulate steps on one multiplier,
// then a two-stage read/multiply pipeline drain and the output register;
// issuing resumes once both are empty. s_tready is low while a start runs.
// A stall on m_tready holds the finished entry and pauses the walk before
// the next entry; requests are taken again once the last step is issued,
// while the final entry is still in the pipeline.
// Configuration (cfg_*) writes the sizes, 0 acting as 1 and values above
// MAX_DIM as MAX_DIM; write only while the block is idle.
// Reset clears control state and sets all sizes to 8; the element stores
// are not cleared and must be loaded before they are used.
module integer_matrix_multiply_core #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [imm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [imm_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [imm_pkg::DATA_W-1:0]     s_tdata,   // row[2:0], col[5:3], value[37:6]
    input  logic [imm_pkg::REQ_W-1:0]      s_tuser,   // req_type[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [imm_pkg::DATA_W-1:0]     m_tdata,   // out_row[2:0], out_col[5:3],
                                                      // out_value[37:6]
    output logic                           m_tlast
);
    import imm_pkg::*;

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int CNT_W  = IDX_W + 1;
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

    logic [CFG_W-1:0]   rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [CNT_W-1:0]   nr, nk, nc;
    logic               in_accept;
    cmd_t               cmd;
    stat_t              stat;
    logic [IDX_W-1:0]   idx_i, idx_j, idx_k;
    logic [POS_W-1:0]   out_row, out_col;
    logic [VALUE_W-1:0] out_value;

    function automatic logic [CNT_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] d;
        if (v == '0)
            d = CNT_W'(1);
        else if (32'(v) > 32'(MAX_DIM))
            d = CNT_W'(MAX_DIM);
        else
            d = CNT_W'(v);
        return d;
    endfunction

    // Size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= CFG_RESET;
            inner_dim_reg <= CFG_RESET;
            cols_b_reg    <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ROWS_A:    rows_a_reg    <= cfg_wdata;
                REG_INNER_DIM: inner_dim_reg <= cfg_wdata;
                REG_COLS_B:    cols_b_reg    <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    assign nr        = eff_dim(rows_a_reg);
    assign nk        = eff_dim(inner_dim_reg);
    assign nc        = eff_dim(cols_b_reg);
    assign in_accept = s_tvalid && s_tready;

    imm_ctrl #(
        .MAX_DIM (MAX_DIM),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_req   (s_tuser),
        .nr       (nr),
        .nk       (nk),
        .nc       (nc),
        .cmd      (cmd),
        .idx_i    (idx_i),
        .idx_j    (idx_j),
        .idx_k    (idx_k),
        .stat     (stat)
    );

    imm_datapath #(
        .MAX_DIM (MAX_DIM),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W),
        .ADDR_W  (ADDR_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .nr        (nr),
        .nk        (nk),
        .nc        (nc),
        .ld_en     (in_accept),
        .ld_req    (s_tuser),
        .ld_row    (s_tdata[2:0]),
        .ld_col    (s_tdata[5:3]),
        .ld_value  (s_tdata[37:6]),
        .cmd       (cmd),
        .idx_i     (idx_i),
        .idx_j     (idx_j),
        .idx_k     (idx_k),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, out_value, out_col, out_row};

endmodule

[tb/tb_integer_matrix_multiply_core.sv]
`timescale 1ns / 1ps

module tb_integer_matrix_multiply_core;
    import imm_pkg::*;

    localparam int DIM = MAX_DIM_DEF;
    // Idle cycles after the last entry, before new sizes or the final check
    localparam int SETTLE_CYCLES = 2 * (DIM + 4);
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // One product entry as it leaves the block
    typedef struct {
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [VALUE_W-1:0] value;
        logic               last;
    } entry_t;

    // One planned request before its value is picked
    typedef struct {
        logic [REQ_W-1:0] req;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } plan_t;

    // Shadow of the sizes and stores; predicts product entries
    class product_checker;
        logic [CFG_W-1:0]   size_reg [3];
        logic [VALUE_W-1:0] a_store [DIM*DIM];
        logic [VALUE_W-1:0] b_store [DIM*DIM];
        entry_t             pending_entries [$];
        int unsigned        mismatches;

        function new();
            foreach (size_reg[i])
                size_reg[i] = CFG_RESET;
            foreach (a_store[i])
            begin
                a_store[i] = '0;
                b_store[i] = '0;
            end
            mismatches = 0;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function int unsigned eff_size(int idx);
            if (size_reg[idx] == 0)
                return 1;
            if (size_reg[idx] > DIM)
                return DIM;
            return size_reg[idx];
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_ROWS_A || idx == REG_INNER_DIM || idx == REG_COLS_B)
                size_reg[idx] = val;
        endfunction

        // True when a load falls inside the current sizes and is stored
        function bit load_lands(logic [REQ_W-1:0] req, logic [POS_W-1:0] r,
                                logic [POS_W-1:0] c);
            if (req == REQ_LOAD_A)
                return r < eff_size(REG_ROWS_A) && c < eff_size(REG_INNER_DIM);
            if (req == REQ_LOAD_B)
                return r < eff_size(REG_INNER_DIM) && c < eff_size(REG_COLS_B);
            return 1'b0;
        endfunction

        // Update the stores or queue every entry of the product
        function void take_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] r,
                                   logic [POS_W-1:0] c, logic [VALUE_W-1:0] v);
            logic [VALUE_W-1:0] acc;
            entry_t             e;
            int unsigned        nr;
            int unsigned        nk;
            int unsigned        nc;
            nr = eff_size(REG_ROWS_A);
            nk = eff_size(REG_INNER_DIM);
            nc = eff_size(REG_COLS_B);
            if (load_lands(req, r, c))
            begin
                if (req == REQ_LOAD_A)
                    a_store[r*DIM + c] = v;
                else
                    b_store[r*DIM + c] = v;
            end
            else if (req == REQ_START)
            begin
                for (int i = 0; i < nr; i++)
                    for (int j = 0; j < nc; j++)
                    begin
                        acc = '0;
                        for (int k = 0; k < nk; k++)
                            acc = acc + a_store[i*DIM + k] * b_store[k*DIM + j];
                        e.row   = POS_W'(i);
                        e.col   = POS_W'(j);
                        e.value = acc;
                        e.last  = (i == nr - 1) && (j == nc - 1);
                        pending_entries.push_back(e);
                    end
            end
        endfunction

        function void check_entry(logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                                  logic [VALUE_W-1:0] v, logic last);
            entry_t e;
            if (pending_entries.size() == 0)
            begin
                report($sformatf("unexpected entry: row %0d col %0d value %h last %0d",
                                 r, c, v, last));
                return;
            end
            e = pending_entries.pop_front();
            if (e.row !== r || e.col !== c || e.value !== v || e.last !== last)
                report($sformatf({"entry mismatch: expected row %0d col %0d value %h ",
                                  "last %0d, got row %0d col %0d value %h last %0d"},
                                 e.row, e.col, e.value, e.last, r, c, v, last));
        endfunction

        function void flush_leftovers();
            if (pending_entries.size() != 0)
                report($sformatf("%0d expected entries never arrived",
                                 pending_entries.size()));
            mismatches += (pending_entries.size() > 1) ? pending_entries.size() - 1 : 0;
            pending_entries.delete();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;   // row[2:0], col[5:3], value[37:6]
    logic [REQ_W-1:0]      s_tuser   = '0;   // req_type[1:0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;          // out_row[2:0], out_col[5:3], out_value[37:6]
    logic                  m_tlast;

    product_checker sb = new();
    bit             a_loaded [DIM*DIM];
    bit             b_loaded [DIM*DIM];
    bit             calm = 1'b0;
    int unsigned    requests_sent = 0;
    int unsigned    entries_seen = 0;

    integer_matrix_multiply_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: case ($urandom_range(0, 3))
                   0: return 32'h8000_0000;
                   1: return 32'h7FFF_FFFF;
                   2: return 32'hFFFF_FFFF;
                   default: return 32'h0000_0000;
               endcase
            1, 2: return VALUE_W'($urandom_range(0, 16)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    // Mostly small sizes; zero and values above the maximum now and then
    function automatic logic [CFG_W-1:0] pick_size();
        case ($urandom_range(0, 11))
            0: return 4'd0;
            1: return 4'd15;
            2: return CFG_W'($urandom_range(9, 14));
            3: return 4'd8;
            4: return CFG_W'($urandom_range(4, 7));
            default: return CFG_W'($urandom_range(1, 3));
        endcase
    endfunction

    // Drive one request and hold it until the transaction completes
    task automatic send_item(logic [REQ_W-1:0] req, logic [POS_W-1:0] r,
                             logic [POS_W-1:0] c, logic [VALUE_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, v, c, r};
        do
            @(posedge clk);
        while (!s_tready);
        if (sb.load_lands(req, r, c))
        begin
            if (req == REQ_LOAD_A)
                a_loaded[r*DIM + c] = 1'b1;
            else
                b_loaded[r*DIM + c] = 1'b1;
        end
        requests_sent++;
        sb.take_request(req, r, c, v);
    endtask

    // Hold off until every expected entry has arrived, then let the block settle
    task automatic wait_drain(int settle);
        s_tvalid <= 1'b0;
        while (sb.pending_entries.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_sizes(logic [CFG_W-1:0] nr, logic [CFG_W-1:0] nk,
                               logic [CFG_W-1:0] nc);
        logic [CFG_ADDR_W-1:0] idx [3];
        logic [CFG_W-1:0]      val [3];
        idx = '{REG_ROWS_A, REG_INNER_DIM, REG_COLS_B};
        val = '{nr, nk, nc};
        for (int i = 0; i < 3; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= val[i];
            @(posedge clk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Load every element the product needs that was never loaded, mix in
    // overwrites and ignored requests, shuffle, then start
    task automatic run_product(int overwrites, int noise);
        plan_t       plan [$];
        plan_t       p;
        int unsigned nr;
        int unsigned nk;
        int unsigned nc;
        int          j;
        nr = sb.eff_size(REG_ROWS_A);
        nk = sb.eff_size(REG_INNER_DIM);
        nc = sb.eff_size(REG_COLS_B);
        for (int i = 0; i < nr; i++)
            for (int k = 0; k < nk; k++)
                if (!a_loaded[i*DIM + k])
                    plan.push_back('{REQ_LOAD_A, POS_W'(i), POS_W'(k)});
        for (int k = 0; k < nk; k++)
            for (int i = 0; i < nc; i++)
                if (!b_loaded[k*DIM + i])
                    plan.push_back('{REQ_LOAD_B, POS_W'(k), POS_W'(i)});
        repeat (overwrites)
        begin
            if ($urandom_range(0, 1) == 0)
                p = '{REQ_LOAD_A, POS_W'($urandom_range(0, nr - 1)),
                      POS_W'($urandom_range(0, nk - 1))};
            else
                p = '{REQ_LOAD_B, POS_W'($urandom_range(0, nk - 1)),
                      POS_W'($urandom_range(0, nc - 1))};
            plan.push_back(p);
        end
        repeat (noise)
        begin
            p = '{REQ_UNUSED, POS_W'($urandom), POS_W'($urandom)};
            case ($urandom_range(0, 2))
                1: if (nk < DIM)
                       p = '{REQ_LOAD_A, POS_W'($urandom), POS_W'($urandom_range(nk, DIM - 1))};
                   else if (nr < DIM)
                       p = '{REQ_LOAD_A, POS_W'($urandom_range(nr, DIM - 1)), POS_W'($urandom)};
                2: if (nc < DIM)
                       p = '{REQ_LOAD_B, POS_W'($urandom), POS_W'($urandom_range(nc, DIM - 1))};
                   else if (nk < DIM)
                       p = '{REQ_LOAD_B, POS_W'($urandom_range(nk, DIM - 1)), POS_W'($urandom)};
                default: ;
            endcase
            plan.push_back(p);
        end
        for (int i = plan.size() - 1; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            p       = plan[i];
            plan[i] = plan[j];
            plan[j] = p;
        end
        foreach (plan[i])
            send_item(plan[i].req, plan[i].row, plan[i].col, pick_value());
        send_item(REQ_START, POS_W'($urandom), POS_W'($urandom), $urandom);
    endtask

    // Result side: check each transaction, stall at random
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                sb.check_entry(m_tdata[2:0], m_tdata[5:3], m_tdata[37:6], m_tlast);
                entries_seen++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [VALUE_W-1:0] a_col [DIM];
        logic [VALUE_W-1:0] b_row [DIM];
        int                 phase;
        a_col = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                  32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000};
        b_row = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0002,
                  32'h0000_0000, 32'h0001_0000, 32'hAAAA_AAAA, 32'h5555_5555};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 8 rows, zero inner size acting as one, cols above the maximum
        calm = 1'b1;
        write_sizes(4'd8, 4'd0, 4'd15);
        for (int i = 0; i < DIM; i++)
            send_item(REQ_LOAD_A, POS_W'(i), 3'd0, a_col[i]);
        for (int i = 0; i < DIM; i++)
            send_item(REQ_LOAD_B, 3'd0, POS_W'(i), b_row[i]);
        // Out-of-range loads and the unused code must leave the stores alone
        send_item(REQ_LOAD_A, 3'd3, 3'd7, 32'h1234_5678);
        send_item(REQ_LOAD_B, 3'd7, 3'd2, 32'h8765_4321);
        send_item(REQ_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
        send_item(REQ_START, 3'd0, 3'd0, 32'h0000_0000);

        // Random phases: new sizes, then one or two products
        phase = 0;
        while (requests_sent < 100 || entries_seen < 60)
        begin
            wait_drain(SETTLE_CYCLES);
            calm = ($urandom_range(0, 3) == 0);
            write_sizes(pick_size(), pick_size(), pick_size());
            run_product($urandom_range(0, 3), $urandom_range(0, 2));
            if (phase == 0 || $urandom_range(0, 1) == 1)
            begin
                if (phase == 0 || $urandom_range(0, 2) == 0)
                    wait_drain(0);
                run_product($urandom_range(1, 4), $urandom_range(0, 1));
            end
            phase++;
        end

        wait_drain(SETTLE_CYCLES);
        sb.flush_leftovers();
        if (sb.mismatches == 0)
            $display("integer_matrix_multiply_core test passed");
        else
            $display("integer_matrix_multiply_core test failed");
        $finish;
    end

    // Drop the run if it hangs
    initial
    begin
        #6_000_000;
        $display("integer_matrix_multiply_core test failed");
        $finish;
    end

endmodule

[sim.f]
design/imm_pkg.sv
design/imm_ctrl.sv
design/imm_datapath.sv
design/integer_matrix_multiply_core.sv
tb/tb_integer_matrix_multiply_core.sv
